@@ hdl/gsr_pkg.sv @@
package gsr_pkg;

  localparam int unsigned CoordW = 21;
  localparam int unsigned CoefW  = 32;
  localparam int unsigned AmpW   = 16;
  localparam int unsigned EntryW = 2 * CoordW + CoefW + AmpW;

  localparam int unsigned DiffW  = 23;
  localparam int unsigned MagW   = 22;
  localparam int unsigned D2W    = 45;
  localparam int unsigned ArgW   = 26;
  localparam int unsigned RemW   = 34;
  localparam int unsigned ProdW  = 47;
  localparam int unsigned TW     = 46;
  localparam int unsigned PW     = 37;

  localparam logic [20:0]      ExpSlope  = 21'd1512775;
  localparam logic [TW-1:0]    ExpBiasQ  = TW'(64'd1072632447 << 16);
  localparam logic [ArgW-1:0]  ArgLimitQ = ArgW'(700 << 16);
  localparam logic [10:0]      LimitMult = 11'd1400;
  localparam logic [10:0]      ExpOffset = 11'd1035;
  localparam logic [10:0]      ShiftMax  = 11'd40;
  localparam logic [4:0]       DivLast   = 5'd25;
  localparam logic [AmpW-1:0]  UnitAmp   = 16'd256;

  localparam logic CfgSpotCount = 1'b0;
  localparam logic CfgUnitAmp   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_SQR, ST_SUM, ST_CMP,
    ST_DIV, ST_EXP, ST_MANT, ST_ACC, ST_DONE
  } state_e;

endpackage

@@ hdl/gsr_ram.sv @@
module gsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/gaussian_spot_renderer.sv @@
// Gaussian spot renderer. A write beat (operation 0) stores one spot. An
// evaluate beat (operation 1) sums the first min(spot_count, MAX_SPOTS)
// spots, visited one after another through one RAM read port and one
// shared radix-2 divider. Each spot passes read, diff, square, sum and
// compare; a spot of size zero then goes to accumulate, a clamped argument
// to exp, mantissa and accumulate, and any other through the divider first.
// An evaluation ends in the done state and then idle before the next beat;
// the result waits in an output register, so the next beat can be taken
// while it is still stalled.
module gaussian_spot_renderer import gsr_pkg::*; #(
  parameter int unsigned MAX_SPOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [5:0]         spot_index_i,
  input  logic signed [20:0] spot_centre_x_i,
  input  logic signed [20:0] spot_centre_y_i,
  input  logic [15:0]        spot_size_i,
  input  logic signed [15:0] spot_amplitude_i,
  input  logic [12:0]        pixel_column_i,
  input  logic [12:0]        pixel_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pixel_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  localparam int unsigned AW   = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
  localparam int unsigned CW   = $clog2(MAX_SPOTS + 1);
  localparam int unsigned ACCW = 33 + $clog2(MAX_SPOTS + 1);

  state_e state_q, state_d;

  logic [6:0]  spot_count_q;
  logic        unit_amp_q;
  logic [12:0] px_q, py_q;
  logic [CW-1:0] idx_q, num_q;

  logic [MagW-1:0]  ax_q, ay_q;
  logic [CoefW-1:0] coef_q;
  logic [42:0]      coef_lim_q;
  logic [AmpW-1:0]  amp_mag_q;
  logic             amp_neg_q;
  logic [43:0]      sqx_q, sqy_q;
  logic [D2W-1:0]   d2_q;
  logic [RemW-1:0]  rem_q;
  logic [ArgW-1:0]  low_q, quo_q, arg_q;
  logic [4:0]       div_cnt_q;
  logic [ProdW-1:0] prod_q;
  logic [PW-1:0]    p_q;
  logic [5:0]       k_q;
  logic             term_zero_q;
  logic signed [ACCW-1:0] acc_q;
  logic               out_valid_q;
  logic signed [31:0] out_q;

  logic in_acc, ram_we, out_load, last_spot;
  logic [CW-1:0] num_d;
  logic [EntryW-1:0] wentry, rentry;
  logic [AW-1:0] raddr;

  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign pixel_value_o = out_q;
  assign ram_we = in_acc && !operation_i && (32'(spot_index_i) < MAX_SPOTS);
  assign wentry = {spot_centre_x_i, spot_centre_y_i,
                   32'(spot_size_i) * 32'(spot_size_i), spot_amplitude_i};
  assign raddr = idx_q[AW-1:0];
  assign last_spot = (idx_q + CW'(1)) == num_q;
  assign num_d = (32'(spot_count_q) > MAX_SPOTS) ? CW'(MAX_SPOTS) : CW'(spot_count_q);

  gsr_ram #(.Width(EntryW), .Depth(MAX_SPOTS), .AddrW(AW)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (AW'(spot_index_i)),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i) begin
          state_d = (num_d == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_SQR;
      ST_SQR:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_CMP;
      ST_CMP: begin
        if (coef_q == '0) state_d = ST_ACC;
        else if (d2_q >= D2W'(coef_lim_q)) state_d = ST_EXP;
        else state_d = ST_DIV;
      end
      ST_DIV:  if (div_cnt_q == DivLast) state_d = ST_EXP;
      ST_EXP:  state_d = ST_MANT;
      ST_MANT: state_d = ST_ACC;
      ST_ACC:  state_d = last_spot ? ST_DONE : ST_READ;
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      spot_count_q <= '0;
      unit_amp_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgSpotCount: spot_count_q <= cfg_data_i;
          CfgUnitAmp:   unit_amp_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  logic [DiffW-1:0] dx, dy;
  logic [CoordW-1:0] rcx, rcy;
  logic [AmpW-1:0] ramp;
  logic [RemW-1:0] sh;
  logic ge;
  logic [TW-1:0] t;
  logic [10:0] kf;
  logic [PW-1:0] mag;
  logic signed [ACCW-1:0] term;

  always_comb begin
    rcx  = rentry[EntryW-1 -: CoordW];
    rcy  = rentry[EntryW-1-CoordW -: CoordW];
    ramp = rentry[AmpW-1:0];
    dx = {2'b00, px_q, 8'h00} - {{2{rcx[CoordW-1]}}, rcx};
    dy = {2'b00, py_q, 8'h00} - {{2{rcy[CoordW-1]}}, rcy};
    sh = {rem_q[RemW-2:0], low_q[ArgW-1]};
    ge = sh >= {1'b0, coef_q, 1'b0};
    t  = ExpBiasQ - TW'(prod_q);
    kf = ExpOffset - {1'b0, t[45:36]};
    mag = p_q >> k_q;
    term = amp_neg_q ? -ACCW'(mag) : ACCW'(mag);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i) begin
          px_q  <= pixel_column_i;
          py_q  <= pixel_row_i;
          num_q <= num_d;
          idx_q <= '0;
          acc_q <= '0;
        end
      end
      ST_DIFF: begin
        ax_q <= dx[DiffW-1] ? MagW'(-dx) : MagW'(dx);
        ay_q <= dy[DiffW-1] ? MagW'(-dy) : MagW'(dy);
        coef_q <= rentry[AmpW +: CoefW];
        coef_lim_q <= 43'(rentry[AmpW +: CoefW]) * 43'(LimitMult);
        amp_mag_q <= unit_amp_q ? UnitAmp : (ramp[AmpW-1] ? -ramp : ramp);
        amp_neg_q <= !unit_amp_q && ramp[AmpW-1];
      end
      ST_SQR: begin
        sqx_q <= 44'(ax_q) * 44'(ax_q);
        sqy_q <= 44'(ay_q) * 44'(ay_q);
      end
      ST_SUM: d2_q <= D2W'(sqx_q) + D2W'(sqy_q);
      ST_CMP: begin
        term_zero_q <= (coef_q == '0);
        arg_q <= ArgLimitQ;
        rem_q <= {1'b0, d2_q[42:10]};
        low_q <= {d2_q[9:0], 16'h0000};
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= ge ? sh - {1'b0, coef_q, 1'b0} : sh;
        low_q <= {low_q[ArgW-2:0], 1'b0};
        quo_q <= {quo_q[ArgW-2:0], ge};
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == DivLast) arg_q <= {quo_q[ArgW-2:0], ge};
      end
      ST_EXP: prod_q <= ProdW'(ExpSlope) * ProdW'(arg_q);
      ST_MANT: begin
        p_q <= PW'(amp_mag_q) * PW'({1'b1, t[35:16]});
        k_q <= kf[5:0];
        term_zero_q <= (kf >= ShiftMax);
      end
      ST_ACC: begin
        if (!term_zero_q) acc_q <= acc_q + term;
        idx_q <= idx_q + CW'(1);
      end
      default: ;
    endcase
    if (out_load) begin
      if (acc_q[ACCW-1:31] == '0 || acc_q[ACCW-1:31] == '1) out_q <= acc_q[31:0];
      else out_q <= acc_q[ACCW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
  end
endmodule

@@ test/gaussian_spot_renderer_test.sv @@
`timescale 1ns / 1ps

module gaussian_spot_renderer_test;
  import gsr_pkg::*;

  localparam int unsigned NumSpots   = 64;
  localparam int unsigned CycleLimit = 25000000;

  typedef struct {
    logic               op;
    logic [5:0]         idx;
    logic signed [20:0] cx;
    logic signed [20:0] cy;
    logic [15:0]        sz;
    logic signed [15:0] amp;
    logic [12:0]        col;
    logic [12:0]        row;
  } spot_beat_t;

  class pixel_sum_board;
    longint          cx_tab[NumSpots];
    longint          cy_tab[NumSpots];
    longint unsigned sq_tab[NumSpots];
    longint          amp_tab[NumSpots];
    int unsigned     spot_count;
    bit              unit_amp;
    logic [31:0]     pixel_q[$];
    int unsigned     errors;
    int unsigned     n_writes;
    int unsigned     n_evals;
    int unsigned     n_pixels;

    function void set_reg(logic idx, logic [6:0] data);
      if (idx == CfgSpotCount) spot_count = 32'(data);
      else unit_amp = data[0];
    endfunction

    function longint spot_term(int i, longint px, longint py);
      longint unsigned q, ax, ay, d2, arg, t, h, e, m, k, mag;
      longint dx, dy, amp;
      q = sq_tab[i];
      if (q == 0) return 0;
      dx = px - cx_tab[i];
      dy = py - cy_tab[i];
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      d2 = ax * ax + ay * ay;
      if (d2 >= 64'd1400 * q) arg = 64'd700 << 16;
      else arg = (d2 << 16) / (64'd2 * q);
      t = (64'd1072632447 << 16) - 64'd1512775 * arg;
      h = t >> 16;
      e = h >> 20;
      m = h & 64'hFFFFF;
      k = 64'd1035 - e;
      if (k >= 40) return 0;
      amp = unit_amp ? 256 : amp_tab[i];
      mag = ((amp < 0 ? -amp : amp) * ((64'd1 << 20) + m)) >> k;
      return amp < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function void absorb_beat(spot_beat_t b);
      longint sum;
      int n;
      if (b.op == 1'b0) begin
        n_writes++;
        cx_tab[b.idx]  = b.cx;
        cy_tab[b.idx]  = b.cy;
        sq_tab[b.idx]  = longint'(b.sz) * longint'(b.sz);
        amp_tab[b.idx] = b.amp;
      end else begin
        n_evals++;
        sum = 0;
        n = spot_count > NumSpots ? NumSpots : spot_count;
        for (int i = 0; i < n; i++)
          sum += spot_term(i, longint'(b.col) * 256, longint'(b.row) * 256);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        pixel_q.push_back(sum[31:0]);
      end
    endfunction

    function void check_pixel(logic [31:0] got);
      logic [31:0] want;
      n_pixels++;
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: pixel_value %h with no beat pending", $time, got);
        return;
      end
      want = pixel_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: pixel_value expected %h actual %h", $time, want, got);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = 1'b0;
  logic [5:0]         spot_index_i = '0;
  logic signed [20:0] spot_centre_x_i = '0;
  logic signed [20:0] spot_centre_y_i = '0;
  logic [15:0]        spot_size_i = '0;
  logic signed [15:0] spot_amplitude_i = '0;
  logic [12:0]        pixel_column_i = '0;
  logic [12:0]        pixel_row_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] pixel_value_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [6:0]         cfg_data_i = '0;

  gaussian_spot_renderer dut (.*);

  pixel_sum_board board = new();
  bit          quiet = 1'b0;
  bit          written[NumSpots];
  int unsigned cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("gaussian_spot_renderer test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) board.check_pixel(pixel_value_o);
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 11);
  end

  function int unsigned prefix_len();
    int unsigned p;
    p = 0;
    while (p < NumSpots && written[p]) p++;
    return p;
  endfunction

  task automatic send_beat(spot_beat_t b);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= b.op;
    spot_index_i     <= b.idx;
    spot_centre_x_i  <= b.cx;
    spot_centre_y_i  <= b.cy;
    spot_size_i      <= b.sz;
    spot_amplitude_i <= b.amp;
    pixel_column_i   <= b.col;
    pixel_row_i      <= b.row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.absorb_beat(b);
    if (b.op == 1'b0) written[b.idx] = 1'b1;
  endtask

  task automatic set_reg(logic idx, logic [6:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pixel_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic spot_beat_t write_beat(int idx, int cx, int cy, int sz, int amp);
    spot_beat_t b;
    b = '{op: 1'b0, idx: 6'(idx), cx: 21'(cx), cy: 21'(cy), sz: 16'(sz),
          amp: 16'(amp), col: 13'($urandom), row: 13'($urandom)};
    return b;
  endfunction

  function automatic spot_beat_t eval_beat(int col, int row);
    spot_beat_t b;
    b = '{op: 1'b1, idx: 6'($urandom), cx: 21'($urandom), cy: 21'($urandom),
          sz: 16'($urandom), amp: 16'($urandom), col: 13'(col), row: 13'(row)};
    return b;
  endfunction

  function automatic int rand_centre();
    if ($urandom_range(99) < 80) return 256 * $urandom_range(0, 80) + $urandom_range(0, 511) - 256;
    return $urandom;
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 80);
    if (r < 95) return $urandom_range(1, 4096);
    return $urandom;
  endfunction

  function automatic spot_beat_t rand_beat(int unsigned pre);
    int r, sz, idx;
    if ($urandom_range(1)) return eval_beat(rand_pos(), rand_pos());
    r = $urandom_range(99);
    if (r < 10) sz = 0;
    else if (r < 15) sz = 65535;
    else if (r < 25) sz = $urandom;
    else sz = $urandom_range(64, 3000);
    idx = (pre < NumSpots && $urandom_range(1)) ? pre : $urandom_range(NumSpots - 1);
    return write_beat(idx, rand_centre(), rand_centre(), sz, $urandom);
  endfunction

  initial begin
    int unsigned pre, cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_reg(CfgSpotCount, 7'd0);
    set_reg(CfgUnitAmp, 7'd0);
    send_beat(eval_beat(1, 1));
    send_beat(eval_beat(4096, 4096));
    send_beat(write_beat(0, 256, 256, 256, 32767));
    send_beat(write_beat(1, 512, 512, 0, 32767));
    send_beat(write_beat(2, -1048576, -1048576, 65535, -32768));
    send_beat(write_beat(3, 1048575, 1048575, 1, 256));
    send_beat(write_beat(63, -1, 1048575, 65535, -1));
    set_reg(CfgSpotCount, 7'd4);
    send_beat(eval_beat(1, 1));
    send_beat(eval_beat(0, 0));
    send_beat(eval_beat(8191, 8191));
    send_beat(eval_beat(4096, 4096));
    send_beat(eval_beat(2, 1));
    set_reg(CfgUnitAmp, 7'd1);
    send_beat(eval_beat(1, 1));
    send_beat(eval_beat(1, 2));

    for (int p = 0; p < 20; p++) begin
      quiet = (p >= 6 && p <= 8);
      pre = prefix_len();
      if (pre == NumSpots && (p % 6 == 5 || p == 19)) begin
        case (p % 3)
          0: cnt = 127;
          1: cnt = 64;
          default: cnt = $urandom_range(65, 127);
        endcase
      end else if ($urandom_range(9) == 0) begin
        cnt = pre;
      end else begin
        cnt = $urandom_range(0, pre < 8 ? pre : 8);
      end
      set_reg(CfgSpotCount, 7'(cnt));
      set_reg(CfgUnitAmp, 7'($urandom_range(1)));
      for (int i = 0; i < 95; i++) send_beat(rand_beat(prefix_len()));
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pixel_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d spot writes and %0d pixel evaluations, %0d results checked",
             board.n_writes, board.n_evals, board.n_pixels);
    if (board.errors == 0) begin
      $display("gaussian_spot_renderer test passed");
    end else begin
      $display("gaussian_spot_renderer test failed");
    end
    $finish;
  end

endmodule
